FILE: rtl/bdeq_pkg.sv
// bdeq_pkg: shared constants, command codes and types for the bounded deque
// no dependencies; compiled first
`timescale 1ns / 1ps

package bdeq_pkg;

	localparam int DEPTH_DEF  = 1024;
	localparam int DATA_W_DEF = 16;

	// command field and capacity register widths are fixed by the item format
	localparam int CMD_W = 3;
	localparam int CAP_W = 11;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_REAR  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_REAR   = 3'd3,
		CMD_PEEK       = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_LOAD
	} state_t;

	// memory control strobes from the sequencer to the ring memory
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ram_ctl_t;

endpackage

FILE: rtl/bdeq_cmd_if.sv
// bdeq_cmd_if: command channel (valid/ready, command code and push value)
// depends on bdeq_pkg
`timescale 1ns / 1ps

interface bdeq_cmd_if #(
	parameter int DATA_W = bdeq_pkg::DATA_W_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic [bdeq_pkg::CMD_W-1:0]   command;
	logic [DATA_W-1:0]            value;

	modport source (output valid, command, value, input ready);
	modport sink   (input valid, command, value, output ready);
endinterface

FILE: rtl/bdeq_rsp_if.sv
// bdeq_rsp_if: result channel (valid/ready, status flags, end values, count)
// depends on bdeq_pkg
`timescale 1ns / 1ps

interface bdeq_rsp_if #(
	parameter int DATA_W = bdeq_pkg::DATA_W_DEF,
	parameter int CNT_W  = $clog2(bdeq_pkg::DEPTH_DEF + 1)
) ();
	logic              valid;
	logic              ready;
	logic              success;
	logic [DATA_W-1:0] front_value;
	logic [DATA_W-1:0] rear_value;
	logic              ends_valid;
	logic              is_empty;
	logic              is_full;
	logic [CNT_W-1:0]  entry_count;

	modport source (output valid, success, front_value, rear_value, ends_valid,
		is_empty, is_full, entry_count, input ready);
	modport sink   (input valid, success, front_value, rear_value, ends_valid,
		is_empty, is_full, entry_count, output ready);
endinterface

FILE: rtl/bdeq_cfg_if.sv
// bdeq_cfg_if: configuration write channel carrying the capacity limit
// depends on bdeq_pkg
`timescale 1ns / 1ps

interface bdeq_cfg_if ();
	logic                       valid;
	logic                       ready;
	logic [bdeq_pkg::CAP_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/bdeq_ring_ram.sv
// bdeq_ring_ram: ring storage, one write port and two registered read ports
// depends on bdeq_pkg
`timescale 1ns / 1ps

module bdeq_ring_ram #(
	parameter int DEPTH  = bdeq_pkg::DEPTH_DEF,
	parameter int DATA_W = bdeq_pkg::DATA_W_DEF,
	parameter int AW     = $clog2(DEPTH)
) (
	input  logic               clk,
	input  bdeq_pkg::ram_ctl_t ctl,
	input  logic [AW-1:0]      wr_addr,
	input  logic [DATA_W-1:0]  wr_data,
	input  logic [AW-1:0]      rd_addr_a,
	input  logic [AW-1:0]      rd_addr_b,
	output logic [DATA_W-1:0]  rd_data_a,
	output logic [DATA_W-1:0]  rd_data_b
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

FILE: rtl/bdeq_ctrl.sv
// bdeq_ctrl: sequencer for one command: pointer update, memory write,
// end reads and the result register; depends on bdeq_pkg and the channel interfaces
`timescale 1ns / 1ps

module bdeq_ctrl #(
	parameter int DEPTH  = bdeq_pkg::DEPTH_DEF,
	parameter int DATA_W = bdeq_pkg::DATA_W_DEF,
	parameter int AW     = $clog2(DEPTH),
	parameter int CNT_W  = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	bdeq_cmd_if.sink                   cmd,
	bdeq_rsp_if.source                 rsp,
	input  logic [bdeq_pkg::CAP_W-1:0] cap,
	output bdeq_pkg::ram_ctl_t         ram_ctl,
	output logic [AW-1:0]              wr_addr,
	output logic [DATA_W-1:0]          wr_data,
	output logic [AW-1:0]              rd_addr_front,
	output logic [AW-1:0]              rd_addr_rear,
	input  logic [DATA_W-1:0]          rd_data_front,
	input  logic [DATA_W-1:0]          rd_data_rear
);

	localparam int CMP_W = (CNT_W > bdeq_pkg::CAP_W) ? CNT_W : bdeq_pkg::CAP_W;
	localparam logic [AW:0]       DEPTH_V = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0]     LAST_IX = AW'(DEPTH - 1);
	localparam logic [CMP_W-1:0]  DEPTH_C = CMP_W'(DEPTH);

	bdeq_pkg::state_t state_q, state_d;

	logic [bdeq_pkg::CMD_W-1:0] command_q;
	logic [DATA_W-1:0]          value_q;
	logic [AW-1:0]              front_q, front_d;
	logic [CNT_W-1:0]           count_q, count_d;
	logic                       success_q, success_d;
	logic                       load_out;

	logic                       rsp_valid_q;
	logic                       rsp_success_q;
	logic [DATA_W-1:0]          rsp_front_q;
	logic [DATA_W-1:0]          rsp_rear_q;
	logic                       rsp_ends_q;
	logic                       rsp_empty_q;
	logic                       rsp_full_q;
	logic [CNT_W-1:0]           rsp_count_q;

	logic [CMP_W-1:0] cap_ext, eff_cap, count_ext;
	logic             has_room, not_empty;
	logic [AW-1:0]    front_inc, front_dec;
	logic [CNT_W-1:0] count_m1;
	logic [AW:0]      push_sum, rear_sum;
	logic [AW-1:0]    push_rear_ix, rear_ix;

	// capacity clipped to the ring depth
	assign cap_ext   = CMP_W'(cap);
	assign eff_cap   = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
	assign count_ext = CMP_W'(count_q);
	assign has_room  = count_ext < eff_cap;
	assign not_empty = count_q != '0;

	// ring index arithmetic, sums stay below twice the depth
	assign front_inc    = (front_q == LAST_IX) ? '0 : front_q + AW'(1);
	assign front_dec    = (front_q == '0) ? LAST_IX : front_q - AW'(1);
	assign count_m1     = count_q - CNT_W'(1);
	assign push_sum     = {1'b0, front_q} + {1'b0, count_q[AW-1:0]};
	assign push_rear_ix = (push_sum >= DEPTH_V) ? AW'(push_sum - DEPTH_V) : push_sum[AW-1:0];
	assign rear_sum     = {1'b0, front_q} + {1'b0, count_m1[AW-1:0]};
	assign rear_ix      = (rear_sum >= DEPTH_V) ? AW'(rear_sum - DEPTH_V) : rear_sum[AW-1:0];

	assign wr_data       = value_q;
	assign rd_addr_front = front_q;
	assign rd_addr_rear  = rear_ix;

	always_comb begin
		state_d     = state_q;
		cmd.ready   = 1'b0;
		ram_ctl     = '0;
		wr_addr     = push_rear_ix;
		front_d     = front_q;
		count_d     = count_q;
		success_d   = success_q;
		load_out    = 1'b0;
		unique case (state_q)
			bdeq_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = bdeq_pkg::ST_WRITE;
				end
			end
			bdeq_pkg::ST_WRITE: begin
				success_d = 1'b0;
				unique case (command_q)
					bdeq_pkg::CMD_PUSH_FRONT: begin
						if (has_room) begin
							front_d       = front_dec;
							count_d       = count_q + CNT_W'(1);
							wr_addr       = front_dec;
							ram_ctl.wr_en = 1'b1;
							success_d     = 1'b1;
						end
					end
					bdeq_pkg::CMD_PUSH_REAR: begin
						if (has_room) begin
							count_d       = count_q + CNT_W'(1);
							ram_ctl.wr_en = 1'b1;
							success_d     = 1'b1;
						end
					end
					bdeq_pkg::CMD_POP_FRONT: begin
						if (not_empty) begin
							front_d   = front_inc;
							count_d   = count_m1;
							success_d = 1'b1;
						end
					end
					bdeq_pkg::CMD_POP_REAR: begin
						if (not_empty) begin
							count_d   = count_m1;
							success_d = 1'b1;
						end
					end
					bdeq_pkg::CMD_PEEK: begin
						success_d = 1'b1;
					end
					default: begin
						success_d = 1'b0;
					end
				endcase
				state_d = bdeq_pkg::ST_READ;
			end
			bdeq_pkg::ST_READ: begin
				ram_ctl.rd_en = 1'b1;
				state_d       = bdeq_pkg::ST_LOAD;
			end
			bdeq_pkg::ST_LOAD: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = bdeq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bdeq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bdeq_pkg::ST_IDLE;
			front_q   <= '0;
			count_q   <= '0;
			success_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			front_q   <= front_d;
			count_q   <= count_d;
			success_q <= success_d;
		end
	end

	// accepted item payload
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			command_q <= cmd.command;
			value_q   <= cmd.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// empty queue shows zero end values
	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_success_q <= success_q;
			rsp_front_q   <= not_empty ? rd_data_front : '0;
			rsp_rear_q    <= not_empty ? rd_data_rear : '0;
			rsp_ends_q    <= not_empty;
			rsp_empty_q   <= !not_empty;
			rsp_full_q    <= count_ext >= eff_cap;
			rsp_count_q   <= count_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.success     = rsp_success_q;
	assign rsp.front_value = rsp_front_q;
	assign rsp.rear_value  = rsp_rear_q;
	assign rsp.ends_valid  = rsp_ends_q;
	assign rsp.is_empty    = rsp_empty_q;
	assign rsp.is_full     = rsp_full_q;
	assign rsp.entry_count = rsp_count_q;

endmodule

FILE: rtl/bounded_double_ended_queue.sv
// bounded_double_ended_queue: top level, capacity register, sequencer and ring memory
// depends on bdeq_pkg, bdeq_cmd_if, bdeq_rsp_if, bdeq_cfg_if, bdeq_ctrl, bdeq_ring_ram
`timescale 1ns / 1ps

// usage
//   cmd: one item per operation: push front, push rear, pop front, pop rear, peek;
//     unused codes change nothing and report failure
//   rsp: exactly one result item per command item, in order: success, front and
//     rear values (zero with ends_valid low when empty), empty, full, count
//   cfg: writes the capacity limit; always ready, write only while idle;
//     values above the ring depth act as the depth
// timing
//   a command item is taken in the idle state; the result appears in the
//   result register after the write step, the end read step and the
//   load step, and the next item is taken back in the idle state after
//   that; one item is handled at a time through the ring memory, so no new
//   item is taken before the result of the last one is loaded
// reset
//   arst_n clears count, front index and result valid; capacity returns to
//   1024; memory contents stay undefined, only held entries are ever shown
// stalls
//   the result register holds while rsp.ready is low; the next item can still
//   be accepted and worked up to the load step, where it waits for the slot

module bounded_double_ended_queue #(
	parameter int DEPTH      = bdeq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = bdeq_pkg::DATA_W_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bdeq_cmd_if.sink   cmd,
	bdeq_rsp_if.source rsp,
	bdeq_cfg_if.sink   cfg
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [bdeq_pkg::CAP_W-1:0] cap_q;
	bdeq_pkg::ram_ctl_t         ram_ctl;
	logic [AW-1:0]              wr_addr;
	logic [DATA_WIDTH-1:0]      wr_data;
	logic [AW-1:0]              rd_addr_front;
	logic [AW-1:0]              rd_addr_rear;
	logic [DATA_WIDTH-1:0]      rd_data_front;
	logic [DATA_WIDTH-1:0]      rd_data_rear;

	// capacity register, writes always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bdeq_pkg::CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.data;
		end
	end

	// command sequencing and result register
	bdeq_ctrl #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_WIDTH),
		.AW     (AW),
		.CNT_W  (CNT_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rsp           (rsp),
		.cap           (cap_q),
		.ram_ctl       (ram_ctl),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_addr_front (rd_addr_front),
		.rd_addr_rear  (rd_addr_rear),
		.rd_data_front (rd_data_front),
		.rd_data_rear  (rd_data_rear)
	);

	// ring storage: written in the write step, both ends read in the read step that follows it,
	// so a freshly pushed entry is already in memory when read back
	bdeq_ring_ram #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_WIDTH),
		.AW     (AW)
	) u_ram (
		.clk       (clk),
		.ctl       (ram_ctl),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_front),
		.rd_addr_b (rd_addr_rear),
		.rd_data_a (rd_data_front),
		.rd_data_b (rd_data_rear)
	);

endmodule

FILE: rtl/bdeq_checker.sv
// bdeq_checker: port-level checks on the deque and its bind to the top level
// depends on bdeq_pkg and bounded_double_ended_queue
`timescale 1ns / 1ps

module bdeq_checker #(
	parameter int DATA_W = bdeq_pkg::DATA_W_DEF,
	parameter int CNT_W  = $clog2(bdeq_pkg::DEPTH_DEF + 1)
) (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [DATA_W-1:0] front_value,
	input logic [DATA_W-1:0] rear_value,
	input logic              ends_valid,
	input logic              is_empty,
	input logic [CNT_W-1:0]  entry_count
);

	// a stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// one item in flight: no acceptance right after an acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted back to back");

	// empty flags agree with the count
	a_empty_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (entry_count == '0)) && (ends_valid == !is_empty))
		else $error("empty flags disagree with count");

	// empty queue shows zero end values
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !ends_valid |-> (front_value == '0) && (rear_value == '0))
		else $error("end values nonzero on empty queue");

endmodule

bind bounded_double_ended_queue bdeq_checker #(
	.DATA_W (DATA_WIDTH),
	.CNT_W  ($clog2(DEPTH + 1))
) u_bdeq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.front_value (rsp.front_value),
	.rear_value  (rsp.rear_value),
	.ends_valid  (rsp.ends_valid),
	.is_empty    (rsp.is_empty),
	.entry_count (rsp.entry_count)
);

FILE: bench/testbench.sv
// testbench: self-checking bench for bounded_double_ended_queue, with an in-bench deque predictor
// depends on bdeq_pkg, bdeq_cmd_if, bdeq_rsp_if, bdeq_cfg_if and bounded_double_ended_queue
`timescale 1ns / 1ps

module testbench;
	import bdeq_pkg::*;

	localparam int RING_DEPTH = DEPTH_DEF;
	localparam int DATA_W     = DATA_W_DEF;
	localparam int IDX_W      = $clog2(DEPTH_DEF);
	localparam int CNT_W      = $clog2(DEPTH_DEF + 1);

	// command codes with no operation behind them
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

	localparam int RANDOM_ITEMS = 1500;
	// extra slack after the last outstanding result has come back
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int MAX_REPORTS  = 10;

	// traffic shaping per phase
	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// what one result item carries
	typedef struct packed {
		logic              success;
		logic [DATA_W-1:0] front_value;
		logic [DATA_W-1:0] rear_value;
		logic              ends_valid;
		logic              is_empty;
		logic              is_full;
		logic [CNT_W-1:0]  entry_count;
	} deque_status_t;

	logic clk = 1'b0;
	logic arst_n;

	bdeq_cmd_if cmd_if ();
	bdeq_rsp_if rsp_if ();
	bdeq_cfg_if cfg_if ();

	bounded_double_ended_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predicted deque contents, mirrored op by op at acceptance time
	logic [DATA_W-1:0] shadow_ring [RING_DEPTH];
	logic [IDX_W-1:0]  shadow_front;
	logic [CNT_W-1:0]  shadow_count;
	logic [CAP_W-1:0]  shadow_capacity;

	// expected result items, oldest first
	deque_status_t pending_status[$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int stall_pct      = 0;

	// apply one command to the shadow deque and return the status it should report
	function automatic deque_status_t apply_deque_op(input logic [CMD_W-1:0] op,
		input logic [DATA_W-1:0] val);
		deque_status_t    st;
		logic [CNT_W-1:0] limit;
		logic [IDX_W-1:0] rear_idx;
		// capacities above the ring depth act as the depth
		limit = (shadow_capacity > CAP_W'(RING_DEPTH)) ? CNT_W'(RING_DEPTH) : shadow_capacity;
		st = '0;
		case (op)
			CMD_PUSH_FRONT: begin
				if (shadow_count < limit) begin
					shadow_front = shadow_front - 1'b1;
					shadow_ring[shadow_front] = val;
					shadow_count = shadow_count + 1'b1;
					st.success = 1'b1;
				end
			end
			CMD_PUSH_REAR: begin
				if (shadow_count < limit) begin
					rear_idx = IDX_W'(shadow_front + shadow_count);
					shadow_ring[rear_idx] = val;
					shadow_count = shadow_count + 1'b1;
					st.success = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (shadow_count != 0) begin
					shadow_front = shadow_front + 1'b1;
					shadow_count = shadow_count - 1'b1;
					st.success = 1'b1;
				end
			end
			CMD_POP_REAR: begin
				if (shadow_count != 0) begin
					shadow_count = shadow_count - 1'b1;
					st.success = 1'b1;
				end
			end
			CMD_PEEK: begin
				st.success = 1'b1;
			end
			default: begin
				st.success = 1'b0;
			end
		endcase
		// end values read zero on an empty deque
		if (shadow_count != 0) begin
			rear_idx = IDX_W'(shadow_front + shadow_count - 1'b1);
			st.front_value = shadow_ring[shadow_front];
			st.rear_value  = shadow_ring[rear_idx];
		end
		st.ends_valid  = (shadow_count != 0);
		st.is_empty    = (shadow_count == 0);
		st.is_full     = (shadow_count >= limit);
		st.entry_count = shadow_count;
		return st;
	endfunction

	function automatic void check_field(input string field, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("mismatch on %s at cycle %0d: expected %0h, got %0h",
					field, cycle_count, want, got);
		end
	endfunction

	// result checker: every accepted result item against the oldest expectation
	always @(posedge clk) begin
		deque_status_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_status.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("result item with no operation pending at cycle %0d", cycle_count);
			end else begin
				want = pending_status.pop_front();
				check_field("success", want.success, rsp_if.success);
				check_field("front_value", want.front_value, rsp_if.front_value);
				check_field("rear_value", want.rear_value, rsp_if.rear_value);
				check_field("ends_valid", want.ends_valid, rsp_if.ends_valid);
				check_field("is_empty", want.is_empty, rsp_if.is_empty);
				check_field("is_full", want.is_full, rsp_if.is_full);
				check_field("entry_count", want.entry_count, rsp_if.entry_count);
			end
		end
	end

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		send_idle_pct = (mode == IDLE_SENDER) ? 58 : (mode == IDLE_BOTH) ? 23 : 0;
		stall_pct     = (mode == IDLE_RECEIVER) ? 58 : (mode == IDLE_BOTH) ? 23 : 0;
	endtask

	// offer one command item, with random idle cycles ahead of it;
	// returns at the edge where it was taken, valid still high
	task automatic send_op(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid   <= 1'b1;
		cmd_if.command <= op;
		cmd_if.value   <= val;
		do @(posedge clk); while (!cmd_if.ready);
		pending_status.push_back(apply_deque_op(op, val));
	endtask

	// drop valid and let every outstanding result come back, then some slack
	task automatic wait_idle();
		@(negedge clk);
		cmd_if.valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// capacity writes only happen with the deque idle
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		wait_idle();
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= cap;
		do @(posedge clk); while (!cfg_if.ready);
		shadow_capacity = cap;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(15);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		return DATA_W'($urandom());
	endfunction

	// mostly pushes or pops by weight, some peeks, a few unused codes
	function automatic logic [CMD_W-1:0] pick_op(input int push_weight);
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
		else if (r < 10)
			return CMD_PEEK;
		else if ($urandom_range(99) < push_weight)
			return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
		return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR;
	endfunction

	// small capacities dominate so full is hit often; extremes show up regularly
	function automatic logic [CAP_W-1:0] pick_capacity();
		int r;
		r = $urandom_range(9);
		case (r)
			0:       return '0;
			1:       return CAP_W'(1);
			2:       return '1;
			3:       return CAP_RESET;
			8:       return CAP_W'($urandom_range(64, 13));
			9:       return CAP_W'($urandom_range(2047));
			default: return CAP_W'($urandom_range(12, 1));
		endcase
	endfunction

	// pops, peek and unused codes on the empty deque after reset
	task automatic test_empty_queue();
		send_op(CMD_PEEK, '1);
		send_op(CMD_POP_FRONT, pick_value());
		send_op(CMD_POP_REAR, pick_value());
		for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
			send_op(CMD_W'(c), '1);
	endtask

	// all-zero and all-one data words through both ends
	task automatic test_value_extremes();
		send_op(CMD_PUSH_FRONT, '0);
		send_op(CMD_PUSH_REAR, '1);
		send_op(CMD_PEEK, '0);
		send_op(CMD_PUSH_FRONT, '1);
		send_op(CMD_POP_REAR, '0);
		send_op(CMD_POP_FRONT, '0);
		send_op(CMD_POP_FRONT, '0);
	endtask

	// zero capacity: pushes bounce, empty and full together
	task automatic test_zero_capacity();
		write_capacity('0);
		send_op(CMD_PUSH_FRONT, pick_value());
		send_op(CMD_PUSH_REAR, pick_value());
		send_op(CMD_PEEK, pick_value());
	endtask

	// fill to a small capacity, then lower it below the count
	task automatic test_capacity_shrink();
		write_capacity(CAP_W'(2));
		send_op(CMD_PUSH_REAR, pick_value());
		send_op(CMD_PUSH_FRONT, pick_value());
		send_op(CMD_PUSH_REAR, pick_value());
		write_capacity(CAP_W'(1));
		send_op(CMD_PUSH_FRONT, pick_value());
		send_op(CMD_POP_REAR, pick_value());
		send_op(CMD_POP_FRONT, pick_value());
	endtask

	// capacity beyond the ring depth
	task automatic test_capacity_above_depth();
		write_capacity('1);
		send_op(CMD_PEEK, pick_value());
	endtask

	// fill the whole ring from both ends so the indexes wrap, overflow it, then drain a bit
	task automatic test_ring_fill(output int items);
		items = 0;
		write_capacity('1);
		set_idling(IDLE_NONE);
		while (shadow_count < CNT_W'(RING_DEPTH)) begin
			send_op($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, pick_value());
			items++;
			// vary the traffic along the way
			if (items % 256 == 0)
				set_idling(idle_mode_t'($urandom_range(3)));
		end
		repeat (4) begin
			send_op($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, pick_value());
			items++;
		end
		repeat (30) begin
			send_op($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR, pick_value());
			items++;
		end
	endtask

	// random phases: capacity, traffic shape and push/pop balance change per phase,
	// the deque contents carry over so capacity often lands below the count
	task automatic test_random_phases(input int budget);
		int sent;
		int phase_len;
		int push_weight;
		sent = 0;
		while (sent < budget) begin
			write_capacity(pick_capacity());
			set_idling(idle_mode_t'($urandom_range(3)));
			case ($urandom_range(2))
				0:       push_weight = 20;
				1:       push_weight = 50;
				default: push_weight = 80;
			endcase
			phase_len = $urandom_range(60, 20);
			repeat (phase_len)
				send_op(pick_op(push_weight), pick_value());
			sent += phase_len;
		end
	endtask

	initial begin
		int fill_items;
		arst_n = 1'b0;
		cmd_if.valid   <= 1'b0;
		cmd_if.command <= CMD_PEEK;
		cmd_if.value   <= '0;
		cfg_if.valid   <= 1'b0;
		cfg_if.data    <= '0;
		shadow_front    = '0;
		shadow_count    = '0;
		shadow_capacity = CAP_RESET;
		set_idling(IDLE_NONE);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part
		test_empty_queue();
		test_value_extremes();
		test_zero_capacity();
		test_capacity_shrink();
		test_capacity_above_depth();

		// random part, the ring fill counts toward the item budget
		test_ring_fill(fill_items);
		test_random_phases(RANDOM_ITEMS - fill_items);
		write_capacity(CAP_RESET);
		set_idling(IDLE_BOTH);
		repeat (20)
			send_op(pick_op(50), pick_value());

		wait_idle();
		if (mismatch_count == 0 && pending_status.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
